>>> sv/smm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smm_pkg
// Shared types and constants of the square matrix multiply unit.
// ---------------------------------------------------------------------------
package smm_pkg;

   localparam int DEF_MAX_SIZE  = 8;
   localparam int DEF_FRAC_BITS = 16;

   localparam int IDX_W  = 3;
   localparam int SIZE_W = 4;
   localparam int DATA_W = 32;
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = PROD_W + 4;
   localparam int CSR_W  = 2;

   typedef enum logic [1:0] {
      ACT_LOAD_A = 2'd0,
      ACT_LOAD_B = 2'd1,
      ACT_START  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      OP_MUL   = 2'd0,
      OP_ADD   = 2'd1,
      OP_SUB   = 2'd2,
      OP_SCALE = 2'd3
   } op_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_SIZE   = 2'd0,
      CSR_OP     = 2'd1,
      CSR_SCALAR = 2'd2,
      CSR_UNUSED = 2'd3
   } csr_type;

   // tag traveling with each operand pair
   typedef struct packed {
      logic   valid;
      logic   first;
      logic   last_k;
      op_type op;
   } alu_ctl_type;

endpackage

>>> sv/smm_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smm_ram
// Element store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module smm_ram
   import smm_pkg::*;
#(
   parameter  int DEPTH  = DEF_MAX_SIZE * DEF_MAX_SIZE,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/smm_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smm_alu
// Shared multiply / add unit with exact accumulator and 32-bit saturation.
// ---------------------------------------------------------------------------
module smm_alu
   import smm_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  alu_ctl_type              ctl,
   input  logic signed [DATA_W-1:0] a_data,
   input  logic signed [DATA_W-1:0] b_data,
   input  logic signed [DATA_W-1:0] scalar,
   output logic                     done,
   output logic        [DATA_W-1:0] value,
   output logic                     overflow
);

   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic signed [DATA_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_sh;
   logic signed [DATA_W:0]   addsub;
   logic signed [PROD_W-1:0] term_in;
   logic signed [PROD_W-1:0] term_ff;
   alu_ctl_type              ctl2_ff;

   logic signed [ACC_W-1:0]  acc_base;
   logic signed [ACC_W-1:0]  sum;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     sum_ovf;
   logic [DATA_W-1:0]        value_ff;
   logic                     overflow_ff;

   // stage 1: product, sum or difference of the operand pair
   assign mul_b   = (ctl.op == OP_SCALE) ? scalar : b_data;
   assign prod    = a_data * mul_b;
   assign prod_sh = prod >>> FRAC_BITS;

   always_comb begin
      addsub  = '0;
      term_in = prod_sh;
      case (ctl.op) inside
         OP_ADD, OP_SUB: begin
            if (ctl.op == OP_ADD) begin
               addsub = (DATA_W+1)'(a_data) + (DATA_W+1)'(b_data);
            end else begin
               addsub = (DATA_W+1)'(a_data) - (DATA_W+1)'(b_data);
            end
            term_in = PROD_W'(addsub);
         end
         default: begin
            term_in = prod_sh;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else begin
         ctl2_ff <= ctl;
      end
      term_ff <= term_in;
   end

   // stage 2: accumulate, saturate on the final term
   assign acc_base = ctl2_ff.first ? '0 : acc_ff;
   assign sum      = acc_base + ACC_W'(term_ff);
   assign sum_ovf  = (sum[ACC_W-1:DATA_W-1] != '0) && (sum[ACC_W-1:DATA_W-1] != '1);
   assign done     = ctl2_ff.valid && ctl2_ff.last_k;

   always_ff @(posedge clock) begin
      if (ctl2_ff.valid) begin
         acc_ff <= sum;
      end
      if (done) begin
         overflow_ff <= sum_ovf;
         if (sum_ovf) begin
            value_ff <= sum[ACC_W-1] ? SAT_MIN : SAT_MAX;
         end else begin
            value_ff <= sum[DATA_W-1:0];
         end
      end
   end

   assign value    = value_ff;
   assign overflow = overflow_ff;

endmodule

>>> sv/square_matrix_multiply_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// square_matrix_multiply_unit
// Loads Q16.16 matrices A and B element by element and, on start, emits
// A*B, A+B, A-B or A*scalar element by element in row-major order.
// ---------------------------------------------------------------------------
//  channel | handshake          | word
//  req     | req_valid/stall    | action, row, col, value
//  rsp     | rsp_valid/stall    | row_res, col_res, value_res, overflow, last
//  csr     | csr_valid/ready    | index, data (size, operation, scalar)
//
//  A load writes its element when req takes it. On start, every result
//  element streams its operand pairs (n for multiply, one otherwise, n being
//  the size in use) through the one shared ALU, drains the ALU pipeline and
//  is then offered on rsp, where a rsp stall holds it. req is stalled for
//  the whole run and during reset. csr is ready whenever reset is low.
//  Reset returns the registers to size 8, multiply, scalar 1.0; element
//  storage is not cleared.
// ---------------------------------------------------------------------------
module square_matrix_multiply_unit
   import smm_pkg::*;
#(
   parameter int MAX_SIZE  = DEF_MAX_SIZE,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [IDX_W-1:0]  req_row,
   input  logic [IDX_W-1:0]  req_col,
   input  logic [DATA_W-1:0] req_value,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [IDX_W-1:0]  rsp_row_res,
   output logic [IDX_W-1:0]  rsp_col_res,
   output logic [DATA_W-1:0] rsp_value_res,
   output logic              rsp_overflow,
   output logic              rsp_last,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [DATA_W-1:0] csr_data
);

   localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SIZE);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_ff;
   op_type            op_ff;
   logic [DATA_W-1:0] scalar_ff;

   logic [IDX_W-1:0]  r_ff, r_in;
   logic [IDX_W-1:0]  c_ff, c_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   alu_ctl_type       issue_ctl;
   alu_ctl_type       ctl1_ff;

   logic [SIZE_W-1:0] n_eff;
   logic [SIZE_W-1:0] n_last;
   logic              req_take;
   logic              load_ok;
   logic              wr_a, wr_b;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
   logic [DATA_W-1:0] a_data, b_data;
   logic              r_end, c_end, k_end;
   logic              elem_last;
   logic              alu_done;
   logic [DATA_W-1:0] alu_value;
   logic              alu_ovf;

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
      return ADDR_W'(32'(row) * MAX_SIZE + 32'(col));
   endfunction

   // configuration
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= SIZE_W'(8);
         op_ff     <= OP_MUL;
         scalar_ff <= DATA_W'(65536);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SIZE:   size_ff   <= csr_data[SIZE_W-1:0];
            CSR_OP:     op_ff     <= op_type'(csr_data[1:0]);
            CSR_SCALAR: scalar_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   assign n_eff  = (size_ff == '0) ? SIZE_W'(1) : (size_ff > SIZE_MAX) ? SIZE_MAX : size_ff;
   assign n_last = n_eff - SIZE_W'(1);

   // loads
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign load_ok   = ({1'b0, req_row} < n_eff) && ({1'b0, req_col} < n_eff);
   assign wr_a      = req_take && (req_action == ACT_LOAD_A) && load_ok;
   assign wr_b      = req_take && (req_action == ACT_LOAD_B) && load_ok;
   assign wr_addr   = elem_addr(req_row, req_col);

   // operand fetch
   assign r_end = ({1'b0, r_ff} == n_last);
   assign c_end = ({1'b0, c_ff} == n_last);
   assign k_end = (op_ff != OP_MUL) || ({1'b0, k_ff} == n_last);
   assign elem_last = r_end && c_end;

   always_comb begin
      if (op_ff == OP_MUL) begin
         rd_a_addr = elem_addr(r_ff, k_ff);
         rd_b_addr = elem_addr(k_ff, c_ff);
      end else begin
         rd_a_addr = elem_addr(r_ff, c_ff);
         rd_b_addr = elem_addr(r_ff, c_ff);
      end
   end

   assign issue_ctl.valid  = (state_ff == ST_ISSUE);
   assign issue_ctl.first  = (k_ff == '0);
   assign issue_ctl.last_k = k_end;
   assign issue_ctl.op     = op_ff;

   smm_ram #(.DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_a_addr),
      .rd_data (a_data)
   );

   smm_ram #(.DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (rd_b_addr),
      .rd_data (b_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
      end else begin
         ctl1_ff <= issue_ctl;
      end
   end

   smm_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl1_ff),
      .a_data   (a_data),
      .b_data   (b_data),
      .scalar   (scalar_ff),
      .done     (alu_done),
      .value    (alu_value),
      .overflow (alu_ovf)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_action == ACT_START)) begin
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (k_end) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (alu_done) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               k_in = '0;
               if (elem_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
                  if (c_end) begin
                     c_in = '0;
                     r_in = r_ff + IDX_W'(1);
                  end else begin
                     c_in = c_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         r_ff     <= '0;
         c_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         k_ff     <= k_in;
      end
   end

   // result word
   assign rsp_valid     = (state_ff == ST_SEND);
   assign rsp_row_res   = r_ff;
   assign rsp_col_res   = c_ff;
   assign rsp_value_res = alu_value;
   assign rsp_overflow  = alu_ovf;
   assign rsp_last      = elem_last;

endmodule
